// File: hdl/cenum_pkg.sv
package cenum_pkg;

  // Largest number of elements the mask can hold
  localparam int unsigned MAX_ELEMENTS = 32;
  localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W = 6;
  localparam int unsigned ELEM_W = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Register map
  localparam logic [CFG_IDX_W-1:0] RegElementCount = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] RegSubsetSize = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] ResetCount = CNT_W'(32);
  localparam logic [CNT_W-1:0] ResetSize = CNT_W'(1);

  typedef logic [MAX_ELEMENTS-1:0] mask_t;

  typedef enum logic [1:0] {
    StIdle,
    StPrep,
    StEmit,
    StAdvance
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_first;
    logic prep;
    logic emit;
    logic advance;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic none;
    logic last;
    logic out_free;
  } stat_t;

  // Clip the element count to the mask width
  function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] count);
    logic [CNT_W-1:0] res;
    res = count;
    if (count > CNT_W'(MAX_ELEMENTS)) begin
      res = CNT_W'(MAX_ELEMENTS);
    end
    return res;
  endfunction

  // First subset: low k positions set, or nothing for empty and bad settings
  function automatic mask_t first_mask(logic [CNT_W-1:0] n, logic [CNT_W-1:0] k);
    mask_t m;
    m = '0;
    if (k != '0 && k <= n) begin
      for (int i = 0; i < MAX_ELEMENTS; i++) begin
        m[i] = (CNT_W'(i) < k);
      end
    end
    return m;
  endfunction

endpackage

// File: hdl/cenum_ctrl.sv
module cenum_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                restart_i,
  input  cenum_pkg::stat_t    stat_i,
  output cenum_pkg::cmd_t     cmd_o,
  output logic                busy_o
);
  import cenum_pkg::*;

  state_e state_q, state_d;

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StPrep;
        end
      end
      StPrep: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (stat_i.none) begin
          state_d = StAdvance;
        end else if (stat_i.out_free && stat_i.last) begin
          state_d = StAdvance;
        end
      end
      StAdvance: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        cmd_o.load_first = in_valid_i && restart_i;
      end
      StPrep: begin
        cmd_o.prep = 1'b1;
      end
      StEmit: begin
        cmd_o.emit = !stat_i.none && stat_i.out_free;
      end
      StAdvance: begin
        cmd_o.advance = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

// File: hdl/cenum_dp.sv
module cenum_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cenum_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cenum_pkg::CNT_W-1:0]          cfg_data_i,
  input  cenum_pkg::cmd_t                      cmd_i,
  output cenum_pkg::stat_t                     stat_o,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [cenum_pkg::ELEM_W-1:0]         element_index_o,
  output logic                                 last_of_subset_o,
  output logic                                 final_subset_o,
  output logic                                 empty_subset_o,
  output logic                                 bad_setting_o
);
  import cenum_pkg::*;

  logic [CNT_W-1:0] count_q, count_d, size_q, size_d;
  mask_t            mask_q, mask_d;
  mask_t            rem_q, rem_d;
  logic [IDX_W-1:0] piv_q;
  logic             fin_q, bad_q, empty_q;
  logic [CNT_W-1:0] above_q, above_d;
  logic             out_valid_q;
  logic [ELEM_W-1:0] idx_q;
  logic             last_q, fin_out_q, empty_out_q, bad_out_q;

  logic [CNT_W-1:0] n_eff;
  mask_t            cand;
  logic [IDX_W-1:0] piv_c;
  logic [IDX_W-1:0] low_idx;
  mask_t            rem_next;
  mask_t            next_mask;
  logic             special;
  logic             out_free;
  logic             reg_hit;

  assign n_eff = eff_count(count_q);
  assign special = bad_q || empty_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign reg_hit = cfg_we_i &&
                   (cfg_index_i == RegElementCount || cfg_index_i == RegSubsetSize);

  // Config registers
  always_comb begin
    count_d = count_q;
    size_d = size_q;
    if (cfg_we_i) begin
      if (cfg_index_i == RegElementCount) begin
        count_d = cfg_data_i;
      end else if (cfg_index_i == RegSubsetSize) begin
        size_d = cfg_data_i;
      end
    end
  end

  // Pivot: highest set bit followed by a clear bit inside the element range
  always_comb begin
    cand = '0;
    piv_c = '0;
    for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
      cand[i] = mask_q[i] && !mask_q[i+1] && ((CNT_W+1)'(i + 1) < {1'b0, n_eff});
    end
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (cand[i]) begin
        piv_c = IDX_W'(i);
      end
    end
  end

  // Lowest remaining index of the current subset
  always_comb begin
    low_idx = '0;
    for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign rem_next = rem_q & (rem_q - mask_t'(1));

  // Previous permutation: keep bits below the pivot, clear the pivot,
  // pack the ones above it plus one right after it
  always_comb begin
    next_mask = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (IDX_W'(i) < piv_q) begin
        next_mask[i] = mask_q[i];
      end else if (IDX_W'(i) == piv_q) begin
        next_mask[i] = 1'b0;
      end else begin
        next_mask[i] = ((CNT_W+1)'(i) - (CNT_W+1)'(piv_q) - (CNT_W+1)'(1))
                       <= {1'b0, above_q};
      end
    end
  end

  // Mask update
  always_comb begin
    mask_d = mask_q;
    if (reg_hit) begin
      mask_d = first_mask(eff_count(count_d), size_d);
    end else if (cmd_i.load_first) begin
      mask_d = first_mask(n_eff, size_q);
    end else if (cmd_i.advance) begin
      if (special) begin
        mask_d = '0;
      end else if (fin_q) begin
        mask_d = first_mask(n_eff, size_q);
      end else begin
        mask_d = next_mask;
      end
    end
  end

  // Walk state for one request
  always_comb begin
    rem_d = rem_q;
    above_d = above_q;
    if (cmd_i.prep) begin
      rem_d = mask_q;
      above_d = '0;
    end else if (cmd_i.emit && !special) begin
      rem_d = rem_next;
      if (low_idx > piv_q) begin
        above_d = above_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= ResetCount;
      size_q <= ResetSize;
      mask_q <= first_mask(eff_count(ResetCount), ResetSize);
    end else begin
      count_q <= count_d;
      size_q <= size_d;
      mask_q <= mask_d;
    end
  end

  // Per-request working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    above_q <= above_d;
    if (cmd_i.prep) begin
      piv_q <= piv_c;
      fin_q <= (cand == '0);
      bad_q <= (size_q > n_eff);
      empty_q <= (size_q == '0);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (special) begin
        idx_q <= '0;
        last_q <= 1'b1;
        fin_out_q <= 1'b1;
        empty_out_q <= !bad_q;
        bad_out_q <= bad_q;
      end else begin
        idx_q <= ELEM_W'(low_idx);
        last_q <= (rem_next == '0);
        fin_out_q <= fin_q;
        empty_out_q <= 1'b0;
        bad_out_q <= 1'b0;
      end
    end
  end

  assign stat_o.none = !special && (rem_q == '0);
  assign stat_o.last = special || (rem_next == '0);
  assign stat_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign element_index_o = idx_q;
  assign last_of_subset_o = last_q;
  assign final_subset_o = fin_out_q;
  assign empty_subset_o = empty_out_q;
  assign bad_setting_o = bad_out_q;

endmodule

// File: hdl/combination_enumerator.sv
// An accepted request passes the prep state (pivot search), then the emit
//   state registers its indices, one index per cycle unless the output stalls,
//   then the mask advance; empty and bad settings give a single beat.
// The next request is taken once the mask advance is done.
// Reset (async, active low): n = 32, k = 1, mask = first subset, no beat held.
module combination_enumerator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 restart_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [cenum_pkg::ELEM_W-1:0]         element_index_o,
  output logic                                 last_of_subset_o,
  output logic                                 final_subset_o,
  output logic                                 empty_subset_o,
  output logic                                 bad_setting_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cenum_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cenum_pkg::CNT_W-1:0]          cfg_data_i
);
  import cenum_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = busy;

  cenum_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .restart_i  (restart_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  cenum_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .element_index_o  (element_index_o),
    .last_of_subset_o (last_of_subset_o),
    .final_subset_o   (final_subset_o),
    .empty_subset_o   (empty_subset_o),
    .bad_setting_o    (bad_setting_o)
  );

endmodule

// File: hdl/cenum_checker.sv
module cenum_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [cenum_pkg::ELEM_W-1:0]         element_index_o,
  input logic                                 last_of_subset_o,
  input logic                                 final_subset_o,
  input logic                                 empty_subset_o,
  input logic                                 bad_setting_o
);

  // A stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(element_index_o)
      && $stable(last_of_subset_o) && $stable(final_subset_o))
    else $error("stalled result beat changed");

  // Empty and bad results stand alone as one final beat at index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (empty_subset_o || bad_setting_o) |->
      last_of_subset_o && final_subset_o && element_index_o == '0
      && !(empty_subset_o && bad_setting_o))
    else $error("malformed empty or bad result");

  // A taken request keeps the input side stalled while it is worked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // Indices rise within a subset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_subset_o ##1 out_valid_o |->
      element_index_o > $past(element_index_o))
    else $error("indices not ascending");

endmodule

bind combination_enumerator cenum_checker u_cenum_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .element_index_o  (element_index_o),
  .last_of_subset_o (last_of_subset_o),
  .final_subset_o   (final_subset_o),
  .empty_subset_o   (empty_subset_o),
  .bad_setting_o    (bad_setting_o)
);

// File: tb/combination_enumerator_checker.sv
`timescale 1ns / 1ps
module combination_enumerator_checker
  import cenum_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 restart_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [ELEM_W-1:0]    element_index_i,
  input  logic                 last_of_subset_i,
  input  logic                 final_subset_i,
  input  logic                 empty_subset_i,
  input  logic                 bad_setting_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          beats_seen_o
);

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [ELEM_W-1:0] idx;
    logic              last;
    logic              fin;
    logic              empty;
    logic              bad;
  } index_beat_t;

  logic [CNT_W-1:0] elem_count_q;
  logic [CNT_W-1:0] subset_size_q;
  mask_t            chosen_q;
  index_beat_t      index_beats_due[$];
  int unsigned      fails;
  int unsigned      beats;

  // Clip n to the mask width
  function automatic int unsigned clipped_count(logic [CNT_W-1:0] count);
    if (count > CNT_W'(MAX_ELEMENTS)) begin
      return MAX_ELEMENTS;
    end
    return 32'(count);
  endfunction

  // Low k positions set; nothing when k is zero or exceeds n
  function automatic mask_t first_subset(int unsigned n, int unsigned k);
    mask_t m;
    m = '0;
    if (k != 0 && k <= n) begin
      for (int unsigned i = 0; i < k; i++) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  // Last chosen position followed by an unchosen one, -1 on the final subset
  function automatic int pivot_of(mask_t m, int unsigned n);
    int p;
    p = -1;
    for (int unsigned i = 0; i + 1 < n; i++) begin
      if (m[i] && !m[i+1]) begin
        p = int'(i);
      end
    end
    return p;
  endfunction

  // Step the mask to its previous permutation over positions 0..n-1
  function automatic mask_t previous_subset(mask_t m, int unsigned n, int unsigned piv);
    int unsigned last_zero;
    int unsigned lo;
    int unsigned hi;
    last_zero = piv;
    for (int unsigned j = piv + 1; j < n; j++) begin
      if (!m[j]) begin
        last_zero = j;
      end
    end
    m[piv]       = 1'b0;
    m[last_zero] = 1'b1;
    lo = piv + 1;
    hi = n - 1;
    while (lo < hi) begin
      if (m[lo] != m[hi]) begin
        m[lo] = ~m[lo];
        m[hi] = ~m[hi];
      end
      lo++;
      hi--;
    end
    return m;
  endfunction

  // Queue the index beats one request produces and advance the mask
  task automatic enumerate_request(logic restart);
    int unsigned n;
    int unsigned k;
    int unsigned total;
    int unsigned got;
    int          piv;
    logic        fin;
    index_beat_t beat;
    n = clipped_count(elem_count_q);
    k = 32'(subset_size_q);
    if (restart) begin
      chosen_q = first_subset(n, k);
    end
    if (k > n) begin
      chosen_q = '0;
      beat = '{idx: '0, last: 1'b1, fin: 1'b1, empty: 1'b0, bad: 1'b1};
      index_beats_due = {index_beats_due, beat};
    end else if (k == 0) begin
      chosen_q = '0;
      beat = '{idx: '0, last: 1'b1, fin: 1'b1, empty: 1'b1, bad: 1'b0};
      index_beats_due = {index_beats_due, beat};
    end else begin
      piv   = pivot_of(chosen_q, n);
      fin   = (piv < 0);
      total = $countones(chosen_q);
      got   = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (chosen_q[i]) begin
          got++;
          beat = '{idx: ELEM_W'(i), last: (got == total), fin: fin,
                   empty: 1'b0, bad: 1'b0};
          index_beats_due = {index_beats_due, beat};
        end
      end
      chosen_q = fin ? first_subset(n, k) : previous_subset(chosen_q, n, unsigned'(piv));
    end
  endtask

  // Track register writes, predict on accepted requests, compare output beats
  always @(posedge clk_i or negedge rst_ni) begin
    index_beat_t seen;
    index_beat_t want;
    if (!rst_ni) begin
      elem_count_q  = ResetCount;
      subset_size_q = ResetSize;
      chosen_q      = first_subset(clipped_count(ResetCount), 32'(ResetSize));
      index_beats_due.delete();
      fails = 0;
      beats = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegElementCount) begin
          elem_count_q = cfg_data_i;
          chosen_q     = first_subset(clipped_count(elem_count_q), 32'(subset_size_q));
        end else if (cfg_index_i == RegSubsetSize) begin
          subset_size_q = cfg_data_i;
          chosen_q      = first_subset(clipped_count(elem_count_q), 32'(subset_size_q));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        enumerate_request(restart_i);
      end
      if (out_valid_i && !out_stall_i) begin
        seen = '{idx: element_index_i, last: last_of_subset_i, fin: final_subset_i,
                 empty: empty_subset_i, bad: bad_setting_i};
        beats++;
        if (index_beats_due.size() == 0) begin
          if (fails < ReportLimit) begin
            $display("%0t: unexpected beat idx=%0d last=%b fin=%b empty=%b bad=%b",
                     $realtime, seen.idx, seen.last, seen.fin, seen.empty, seen.bad);
          end
          fails++;
        end else begin
          want = index_beats_due.pop_front();
          if (seen.idx !== want.idx || seen.last !== want.last || seen.fin !== want.fin ||
              seen.empty !== want.empty || seen.bad !== want.bad) begin
            if (fails < ReportLimit) begin
              $display("%0t: mismatch idx %0d/%0d last %b/%b fin %b/%b empty %b/%b bad %b/%b",
                       $realtime, want.idx, seen.idx, want.last, seen.last, want.fin,
                       seen.fin, want.empty, seen.empty, want.bad, seen.bad);
            end
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= index_beats_due.size();
    beats_seen_o <= beats;
  end

endmodule

// File: tb/combination_enumerator_tb.sv
`timescale 1ns / 1ps
module combination_enumerator_tb;
  import cenum_pkg::*;

  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned PhaseItems   = 23;
  localparam int unsigned MaxGap       = 60;

  // Indexes outside the register map: writes there must leave state alone
  localparam logic [CFG_IDX_W-1:0] RegSpareLo = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] RegSpareHi = CFG_IDX_W'(3);

  typedef enum int unsigned {
    PaceSteady,
    PaceSenderIdle,
    PaceReceiverStall,
    PaceBothLight
  } pace_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 restart = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ELEM_W-1:0]    element_index;
  logic                 last_of_subset;
  logic                 final_subset;
  logic                 empty_subset;
  logic                 bad_setting;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_data = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_seen;
  int unsigned send_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned requests = 0;
  int unsigned reg_writes = 0;
  int unsigned quiet = 0;

  combination_enumerator dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .restart_i        (restart),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .element_index_o  (element_index),
    .last_of_subset_o (last_of_subset),
    .final_subset_o   (final_subset),
    .empty_subset_o   (empty_subset),
    .bad_setting_o    (bad_setting),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  combination_enumerator_checker subset_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .restart_i        (restart),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .element_index_i  (element_index),
    .last_of_subset_i (last_of_subset),
    .final_subset_i   (final_subset),
    .empty_subset_i   (empty_subset),
    .bad_setting_i    (bad_setting),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .beats_seen_o     (beats_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stall the output side at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // End the run when no channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("combination_enumerator_tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic set_pace(pace_e pace);
    case (pace)
      PaceSenderIdle: begin
        send_pct = 85;
        stall_pct <= 0;
      end
      PaceReceiverStall: begin
        send_pct = 0;
        stall_pct <= 85;
      end
      PaceBothLight: begin
        send_pct = 7;
        stall_pct <= 7;
      end
      default: begin
        send_pct = 0;
        stall_pct <= 0;
      end
    endcase
  endtask

  // Offer one request beat, idling first at the sender rate
  task automatic push_request(logic rs);
    int unsigned gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(0, 99) < send_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    requests++;
  endtask

  // Drop valid and wait until every predicted beat has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write one register once the block has gone idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  task automatic apply_setting(int unsigned n, int unsigned k);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(RegElementCount, CNT_W'(n));
      write_reg(RegSubsetSize, CNT_W'(k));
    end else begin
      write_reg(RegSubsetSize, CNT_W'(k));
      write_reg(RegElementCount, CNT_W'(n));
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned m;
    int unsigned pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset setting, then a restart back to the first subset
    set_pace(PaceSteady);
    push_request(1'b0);
    push_request(1'b0);
    push_request(1'b1);

    // Full width: all 32 indices in one subset, which is also the final one
    apply_setting(32, 32);
    push_request(1'b0);
    push_request(1'b0);

    // Empty subset, zero count with k of zero, then zero count with k of one
    write_reg(RegSubsetSize, CNT_W'(0));
    push_request(1'b0);
    write_reg(RegElementCount, CNT_W'(0));
    push_request(1'b1);
    write_reg(RegSubsetSize, CNT_W'(1));
    push_request(1'b0);

    // Count above the mask width clips to 32; oversized k is a bad setting
    apply_setting(63, 63);
    push_request(1'b0);
    write_reg(RegSubsetSize, CNT_W'(33));
    push_request(1'b0);
    write_reg(RegSubsetSize, CNT_W'(2));
    push_request(1'b0);
    push_request(1'b0);

    // Single element: every subset is the final one
    apply_setting(1, 1);
    push_request(1'b0);
    push_request(1'b0);

    // Walk through a wrap; spare register writes must not disturb the mask
    apply_setting(4, 2);
    repeat (4) push_request(1'b0);
    write_reg(RegSpareHi, CNT_W'(6'h3F));
    write_reg(RegSpareLo, CNT_W'(6'h15));
    repeat (3) push_request(1'b0);
    push_request(1'b1);

    // Random settings, mostly small enough to wrap, with rare restarts
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      set_pace(pace_e'(phase % 4));
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        n = $urandom_range(1, 7);
        k = $urandom_range(1, n);
      end else if (pick == 7) begin
        n = $urandom_range(0, 40);
        k = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(n + 1, 63);
      end else begin
        n = $urandom_range(20, 63);
        m = (n > MAX_ELEMENTS) ? MAX_ELEMENTS : n;
        k = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(m - 2, m);
      end
      apply_setting(n, k);
      repeat (PhaseItems) push_request($urandom_range(0, 9) == 0);
    end

    // Let the last beats out, then give the block time to settle
    set_pace(PaceSteady);
    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d requests across %0d register writes and checked %0d index beats.",
             requests, reg_writes, beats_seen);
    $display("Settings spanned empty, oversized, clipped and full-width subsets.");
    if (fail_count == 0 && pending == 0) begin
      $display("combination_enumerator_tb passed");
    end else begin
      $display("combination_enumerator_tb failed");
    end
    $finish;
  end

endmodule
